[hw/rtl/des_pkg.sv]
// shared constants, types and helpers for the directory entry sorter
`timescale 1ns / 1ps

package des_pkg;

    // default sizes
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int NAME_LEN_DEF    = 64;

    // port field widths
    localparam int CFG_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 6;

    // reset value of the entry limit register
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

    // case folding bounds
    localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;

    // back end status seen by the front end
    typedef struct packed {
        logic busy;
    } back_status_t;

    // fold upper case ascii letters to lower case
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z)
        begin
            r = c - CHAR_UP_A + CHAR_LO_A;
        end
        return r;
    endfunction

endpackage

[hw/rtl/des_front.sv]
// front end: accepts name characters, tracks entries and writes the stores
`timescale 1ns / 1ps

module des_front #(
    parameter int MAX_ENTRIES = 64,
    parameter int NAME_LEN    = 64,
    localparam int IW   = $clog2(MAX_ENTRIES),
    localparam int CPW  = $clog2(NAME_LEN),
    localparam int CNTW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [des_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       is_dir,
    input  logic [des_pkg::CHAR_W-1:0] name_char,
    input  logic                       end_of_name,
    input  logic                       end_of_list,
    input  des_pkg::back_status_t      back_status,
    input  logic                       job_pending,
    output logic                       job_push,
    output logic [CNTW-1:0]            job_count,
    output logic                       nw_en,
    output logic [IW+CPW-1:0]          nw_addr,
    output logic [des_pkg::CHAR_W-1:0] nw_data,
    output logic                       mw_en,
    output logic [IW-1:0]              mw_addr,
    output logic [CPW:0]               mw_data
);
    import des_pkg::*;

    localparam logic [7:0]     MAX8     = 8'(MAX_ENTRIES);
    localparam logic [CPW-1:0] LAST_POS = CPW'(NAME_LEN - 1);

    logic [CFG_W-1:0] max_reg;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [CPW-1:0]   cp_reg, cp_next;
    logic             kept_reg, kept_next;
    logic             dir_reg, dir_next;

    logic       accept;
    logic       kept_now;
    logic       room;
    logic       dir_bit;
    logic       end_any;
    logic [7:0] lim8;
    logic [CNTW-1:0] cnt_inc;

    // hold off while a listing is queued, being sorted or being sent out
    assign in_stall = job_pending || back_status.busy;
    assign accept   = in_valid && !in_stall;

    // entry limit and keep decision on the first character
    assign lim8     = ({1'b0, max_reg} > MAX8) ? MAX8 : {1'b0, max_reg};
    assign kept_now = (cp_reg == '0) ? (8'(cnt_reg) < lim8) : kept_reg;
    assign room     = cp_reg < LAST_POS;
    assign dir_bit  = (cp_reg == '0) ? is_dir : dir_reg;
    assign end_any  = end_of_name || end_of_list;
    assign cnt_inc  = cnt_reg + CNTW'(kept_now);

    // store write ports
    assign nw_en   = accept && kept_now && room;
    assign nw_addr = {cnt_reg[IW-1:0], cp_reg};
    assign nw_data = name_char;
    assign mw_en   = nw_en;
    assign mw_addr = cnt_reg[IW-1:0];
    assign mw_data = {dir_bit, cp_reg + CPW'(1)};

    // hand a finished listing to the back end
    assign job_push  = accept && end_of_list && (cnt_inc != '0);
    assign job_count = cnt_inc;

    // next state of the entry tracker
    always_comb
    begin
        cnt_next  = cnt_reg;
        cp_next   = cp_reg;
        kept_next = kept_reg;
        dir_next  = dir_reg;
        if (accept)
        begin
            dir_next  = dir_bit;
            kept_next = kept_now;
            if (room)
            begin
                cp_next = cp_reg + CPW'(1);
            end
            if (end_any)
            begin
                cp_next   = '0;
                kept_next = 1'b0;
                cnt_next  = cnt_inc;
            end
            if (end_of_list)
            begin
                cnt_next = '0;
            end
        end
    end

    // entry tracker and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= MAX_ENTRIES_RST;
            cnt_reg  <= '0;
            cp_reg   <= '0;
            kept_reg <= 1'b0;
            dir_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            cnt_reg  <= cnt_next;
            cp_reg   <= cp_next;
            kept_reg <= kept_next;
            dir_reg  <= dir_next;
        end
    end

    // entry count never passes the store depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= MAX_ENTRIES)
        else $error("entry count beyond store depth");

    // an empty listing is never queued
    a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> job_count != '0)
        else $error("empty listing queued");

    // end of list restarts the tracker
    a_list_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_list |=> cnt_reg == '0 && cp_reg == '0)
        else $error("tracker not cleared after end of list");

endmodule

[hw/rtl/des_job_fifo.sv]
// two entry queue of sort jobs between front and back end
`timescale 1ns / 1ps

module des_job_fifo #(
    parameter int W = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] pop_data
);
    import des_pkg::*;

    logic [W-1:0] slot_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   fill_reg;

    assign not_empty = fill_reg != 2'd0;
    assign pop_data  = slot_reg[rp_reg];

    // pointer and fill tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop && not_empty)
            begin
                rp_reg <= !rp_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop && not_empty);
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    // queue must not overflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> fill_reg != 2'd2)
        else $error("job queue overflow");

endmodule

[hw/rtl/des_back.sv]
// back end: stores, insertion sort sequencer and result output
`timescale 1ns / 1ps

module des_back #(
    parameter int MAX_ENTRIES = 64,
    parameter int NAME_LEN    = 64,
    localparam int IW   = $clog2(MAX_ENTRIES),
    localparam int CPW  = $clog2(NAME_LEN),
    localparam int CNTW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        nw_en,
    input  logic [IW+CPW-1:0]           nw_addr,
    input  logic [des_pkg::CHAR_W-1:0]  nw_data,
    input  logic                        mw_en,
    input  logic [IW-1:0]               mw_addr,
    input  logic [CPW:0]                mw_data,
    input  logic                        job_valid,
    input  logic [CNTW-1:0]             job_count,
    output logic                        job_pop,
    output des_pkg::back_status_t       back_status,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [des_pkg::INDEX_W-1:0] entry_index,
    output logic                        last_rank
);
    import des_pkg::*;

    localparam int NAME_DEPTH = MAX_ENTRIES << CPW;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_KEY_RD, S_KEY_LD, S_Y_RD, S_Y_LD, S_META, S_CHAR,
        S_SHIFT, S_PLACE, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
    } state_t;

    // memories
    logic [CHAR_W-1:0] name_mem [NAME_DEPTH];
    logic [CPW:0]      meta_mem [MAX_ENTRIES];
    logic [IW-1:0]     so_mem   [MAX_ENTRIES];

    logic [CHAR_W-1:0] name_a_q, name_b_q;
    logic [CPW:0]      meta_a_q, meta_b_q;
    logic [IW-1:0]     so_q;

    state_t          state_reg;
    logic [CNTW-1:0] count_reg, i_reg, j_reg, r_reg;
    logic [IW-1:0]   key_reg, y_reg, idx_reg;
    logic [CPW-1:0]  k_reg, n_reg;
    logic            lt_reg, valid_reg, last_reg;

    logic            so_we;
    logic [IW-1:0]   so_waddr, so_wdata, so_raddr;
    logic [CPW-1:0]  k_addr;

    logic              dx, dy;
    logic [CPW-1:0]    lx, ly, nmin;
    logic [CHAR_W-1:0] cx, cy;

    assign job_pop          = (state_reg == S_IDLE) && job_valid;
    assign back_status.busy = state_reg != S_IDLE;
    assign out_valid        = valid_reg;
    assign entry_index      = INDEX_W'(idx_reg);
    assign last_rank        = last_reg;

    // comparison operands
    assign dx   = meta_a_q[CPW];
    assign dy   = meta_b_q[CPW];
    assign lx   = meta_a_q[CPW-1:0];
    assign ly   = meta_b_q[CPW-1:0];
    assign nmin = (lx < ly) ? lx : ly;
    assign cx   = fold_char(name_a_q);
    assign cy   = fold_char(name_b_q);

    // memory addressing per sequencer step
    always_comb
    begin
        so_we    = 1'b0;
        so_waddr = '0;
        so_wdata = '0;
        so_raddr = '0;
        k_addr   = '0;
        case (state_reg)
            S_INIT:
            begin
                so_we    = 1'b1;
                so_waddr = i_reg[IW-1:0];
                so_wdata = i_reg[IW-1:0];
            end
            S_KEY_RD:    so_raddr = i_reg[IW-1:0];
            S_Y_RD:      so_raddr = IW'(j_reg - CNTW'(1));
            S_CHAR:      k_addr   = k_reg + CPW'(1);
            S_SHIFT:
            begin
                so_we    = 1'b1;
                so_waddr = j_reg[IW-1:0];
                so_wdata = y_reg;
            end
            S_PLACE:
            begin
                so_we    = 1'b1;
                so_waddr = j_reg[IW-1:0];
                so_wdata = key_reg;
            end
            S_EMIT_RD:   so_raddr = r_reg[IW-1:0];
            default:     k_addr   = '0;
        endcase
    end

    // name store, two registered read ports
    always_ff @(posedge clk)
    begin
        if (nw_en)
        begin
            name_mem[nw_addr] <= nw_data;
        end
        name_a_q <= name_mem[{key_reg, k_addr}];
        name_b_q <= name_mem[{y_reg, k_addr}];
    end

    // flag and length store, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            meta_mem[mw_addr] <= mw_data;
        end
        meta_a_q <= meta_mem[key_reg];
        meta_b_q <= meta_mem[so_q];
    end

    // sorted order store
    always_ff @(posedge clk)
    begin
        if (so_we)
        begin
            so_mem[so_waddr] <= so_wdata;
        end
        so_q <= so_mem[so_raddr];
    end

    // sort and output sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            r_reg     <= '0;
            key_reg   <= '0;
            y_reg     <= '0;
            idx_reg   <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            lt_reg    <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        count_reg <= job_count;
                        i_reg     <= '0;
                        state_reg <= S_INIT;
                    end
                end
                // identity order
                S_INIT:
                begin
                    if (i_reg + CNTW'(1) == count_reg)
                    begin
                        i_reg     <= CNTW'(1);
                        r_reg     <= '0;
                        state_reg <= (count_reg == CNTW'(1)) ? S_EMIT_RD : S_KEY_RD;
                    end
                    else
                    begin
                        i_reg <= i_reg + CNTW'(1);
                    end
                end
                S_KEY_RD: state_reg <= S_KEY_LD;
                S_KEY_LD:
                begin
                    key_reg   <= so_q;
                    j_reg     <= i_reg;
                    state_reg <= S_Y_RD;
                end
                S_Y_RD: state_reg <= (j_reg == '0) ? S_PLACE : S_Y_LD;
                S_Y_LD:
                begin
                    y_reg     <= so_q;
                    state_reg <= S_META;
                end
                // directory flag, or length when either name is empty, else start the character walk
                S_META:
                begin
                    lt_reg <= lx < ly;
                    n_reg  <= nmin;
                    k_reg  <= '0;
                    if (dx != dy)
                    begin
                        state_reg <= dx ? S_SHIFT : S_PLACE;
                    end
                    else if (nmin == '0)
                    begin
                        state_reg <= (lx < ly) ? S_SHIFT : S_PLACE;
                    end
                    else
                    begin
                        state_reg <= S_CHAR;
                    end
                end
                // one character pair per cycle
                S_CHAR:
                begin
                    if (cx != cy)
                    begin
                        state_reg <= (cx < cy) ? S_SHIFT : S_PLACE;
                    end
                    else if ({1'b0, k_reg} + (CPW+1)'(1) == {1'b0, n_reg})
                    begin
                        state_reg <= lt_reg ? S_SHIFT : S_PLACE;
                    end
                    else
                    begin
                        k_reg <= k_reg + CPW'(1);
                    end
                end
                S_SHIFT:
                begin
                    j_reg     <= j_reg - CNTW'(1);
                    state_reg <= S_Y_RD;
                end
                S_PLACE:
                begin
                    if (i_reg + CNTW'(1) == count_reg)
                    begin
                        r_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CNTW'(1);
                        state_reg <= S_KEY_RD;
                    end
                end
                S_EMIT_RD: state_reg <= S_EMIT_LD;
                S_EMIT_LD:
                begin
                    idx_reg   <= so_q;
                    last_reg  <= r_reg + CNTW'(1) == count_reg;
                    valid_reg <= 1'b1;
                    state_reg <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT:
                begin
                    if (!out_stall)
                    begin
                        valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            r_reg     <= r_reg + CNTW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result only shown while waiting for its transfer
    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> state_reg == S_EMIT_WAIT)
        else $error("result valid outside output step");

    // scan position never passes the key position
    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_Y_RD |-> j_reg <= i_reg && i_reg < count_reg)
        else $error("insertion position out of range");

    // character walk stays inside the shorter name
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHAR |-> k_reg < n_reg)
        else $error("character index beyond compare length");

    // last transfer ends the listing
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_stall && last_reg |=> state_reg == S_IDLE)
        else $error("sequencer busy after last result");

endmodule

[hw/rtl/directory_entry_sorter.sv]
// top level of the directory entry sorter
`timescale 1ns / 1ps

//  channel   handshake              payload
//  config    cfg_we                 cfg_wdata (max_entries)
//  input     in_valid / in_stall    is_dir, name_char, end_of_name, end_of_list
//  output    out_valid / out_stall  entry_index, last_rank
//
//  characters load one per cycle while no listing is queued and the back end is idle
//  after end of list the input stalls until the last index has transferred
//  sorting writes the identity order, then for each inserted key reads the key
//  and, per comparison, the neighbour index, its flag and length, and walks the
//  character pairs if needed; each result is read, then held until transferred
//  the comparison walk over the single name store read pair sets the sort time
//  reset clears the counters only; the stores need no clearing pass

module directory_entry_sorter #(
    parameter int MAX_ENTRIES = des_pkg::MAX_ENTRIES_DEF,
    parameter int NAME_LEN    = des_pkg::NAME_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [des_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        is_dir,
    input  logic [des_pkg::CHAR_W-1:0]  name_char,
    input  logic                        end_of_name,
    input  logic                        end_of_list,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [des_pkg::INDEX_W-1:0] entry_index,
    output logic                        last_rank
);
    import des_pkg::*;

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CPW  = $clog2(NAME_LEN);
    localparam int CNTW = $clog2(MAX_ENTRIES + 1);

    back_status_t      back_status;
    logic              job_push, job_pop, job_valid;
    logic [CNTW-1:0]   push_count, pop_count;
    logic              nw_en, mw_en;
    logic [IW+CPW-1:0] nw_addr;
    logic [CHAR_W-1:0] nw_data;
    logic [IW-1:0]     mw_addr;
    logic [CPW:0]      mw_data;

    // front end
    des_front #(.MAX_ENTRIES(MAX_ENTRIES), .NAME_LEN(NAME_LEN)) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .is_dir(is_dir), .name_char(name_char),
        .end_of_name(end_of_name), .end_of_list(end_of_list),
        .back_status(back_status), .job_pending(job_valid),
        .job_push(job_push), .job_count(push_count),
        .nw_en(nw_en), .nw_addr(nw_addr), .nw_data(nw_data),
        .mw_en(mw_en), .mw_addr(mw_addr), .mw_data(mw_data)
    );

    // job queue
    des_job_fifo #(.W(CNTW)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(job_push), .push_data(push_count),
        .pop(job_pop), .not_empty(job_valid), .pop_data(pop_count)
    );

    // back end
    des_back #(.MAX_ENTRIES(MAX_ENTRIES), .NAME_LEN(NAME_LEN)) u_back (
        .clk(clk), .rst_n(rst_n),
        .nw_en(nw_en), .nw_addr(nw_addr), .nw_data(nw_data),
        .mw_en(mw_en), .mw_addr(mw_addr), .mw_data(mw_data),
        .job_valid(job_valid), .job_count(pop_count), .job_pop(job_pop),
        .back_status(back_status),
        .out_valid(out_valid), .out_stall(out_stall),
        .entry_index(entry_index), .last_rank(last_rank)
    );

endmodule

[tb/sv/directory_entry_sorter_checker.sv]
// listing predictor and result checker for the directory entry sorter
`timescale 1ns / 1ps

module directory_entry_sorter_checker
    import des_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int NAME_LEN    = NAME_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               is_dir,
    input  logic [CHAR_W-1:0]  name_char,
    input  logic               end_of_name,
    input  logic               end_of_list,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic               last_rank,
    output int                 pending,
    output int                 failures
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               last;
    } rank_t;

    // shadow copy of the listing
    logic [CHAR_W-1:0] names [MAX_ENTRIES][NAME_LEN];
    int unsigned       lens  [MAX_ENTRIES];
    logic              dirs  [MAX_ENTRIES];
    int unsigned       order [MAX_ENTRIES];
    int unsigned       loaded;
    int unsigned       char_pos;
    logic              keeping;
    logic [CFG_W-1:0]  entry_limit;
    rank_t             ranks_due [$];
    int                fail_count = 0;

    assign pending  = ranks_due.size();
    assign failures = fail_count;

    function automatic logic [CHAR_W-1:0] lower_case(input logic [CHAR_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // directories first, then folded names, shorter prefix first
    function automatic logic sorts_ahead(input int unsigned x, input int unsigned y);
        int unsigned n;
        logic [CHAR_W-1:0] cx;
        logic [CHAR_W-1:0] cy;
        if (dirs[x] != dirs[y])
        begin
            return dirs[x];
        end
        n = (lens[x] < lens[y]) ? lens[x] : lens[y];
        for (int unsigned k = 0; k < n; k++)
        begin
            cx = lower_case(names[x][k]);
            cy = lower_case(names[y][k]);
            if (cx != cy)
            begin
                return cx < cy;
            end
        end
        return lens[x] < lens[y];
    endfunction

    // stable insertion sort, then queue the ranks
    task automatic rank_listing();
        int unsigned held;
        int unsigned j;
        rank_t r;
        for (int unsigned i = 0; i < loaded; i++)
        begin
            order[i] = i;
        end
        for (int unsigned i = 1; i < loaded; i++)
        begin
            held = order[i];
            j = i;
            while (j > 0 && sorts_ahead(held, order[j-1]))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = held;
        end
        for (int unsigned i = 0; i < loaded; i++)
        begin
            r.index = order[i][INDEX_W-1:0];
            r.last  = (i + 1 == loaded);
            ranks_due.push_back(r);
        end
    endtask

    // one accepted character
    task automatic take_char();
        int unsigned cap;
        cap = (entry_limit > MAX_ENTRIES) ? MAX_ENTRIES : entry_limit;
        if (char_pos == 0)
        begin
            keeping = loaded < cap;
            if (keeping)
            begin
                dirs[loaded] = is_dir;
                lens[loaded] = 0;
            end
        end
        if (char_pos < NAME_LEN - 1)
        begin
            if (keeping && loaded < MAX_ENTRIES)
            begin
                names[loaded][char_pos] = name_char;
                lens[loaded] = char_pos + 1;
            end
            char_pos++;
        end
        if (end_of_name || end_of_list)
        begin
            if (keeping && loaded < MAX_ENTRIES)
            begin
                loaded++;
            end
            keeping  = 1'b0;
            char_pos = 0;
        end
        if (end_of_list)
        begin
            rank_listing();
            loaded   = 0;
            char_pos = 0;
        end
    endtask

    // compare one result transfer against the oldest expectation
    task automatic check_rank();
        rank_t want;
        if (ranks_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("unexpected result: entry_index %0d last_rank %0b",
                         entry_index, last_rank);
            end
            return;
        end
        want = ranks_due.pop_front();
        if (want.index !== entry_index || want.last !== last_rank)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("result mismatch: expected index %0d last %0b, got index %0d last %0b",
                         want.index, want.last, entry_index, last_rank);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded      = 0;
            char_pos    = 0;
            keeping     = 1'b0;
            entry_limit = MAX_ENTRIES_RST;
            ranks_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                entry_limit = cfg_wdata;
            end
            if (in_valid && !in_stall)
            begin
                take_char();
            end
            if (out_valid && !out_stall)
            begin
                check_rank();
            end
        end
    end

endmodule

[tb/sv/testbench.sv]
// stimulus and verdict for the directory entry sorter
`timescale 1ns / 1ps

module testbench;
    import des_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               is_dir = 1'b0;
    logic [CHAR_W-1:0]  name_char = 8'h61;
    logic               end_of_name = 1'b0;
    logic               end_of_list = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [INDEX_W-1:0] entry_index;
    logic               last_rank;
    int                 pending;
    int                 failures;
    int                 chars_sent = 0;
    logic               quiet = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    directory_entry_sorter dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .is_dir(is_dir),
        .name_char(name_char), .end_of_name(end_of_name), .end_of_list(end_of_list),
        .out_valid(out_valid), .out_stall(out_stall),
        .entry_index(entry_index), .last_rank(last_rank)
    );

    directory_entry_sorter_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .is_dir(is_dir),
        .name_char(name_char), .end_of_name(end_of_name), .end_of_list(end_of_list),
        .out_valid(out_valid), .out_stall(out_stall),
        .entry_index(entry_index), .last_rank(last_rank),
        .pending(pending), .failures(failures)
    );

    // one character transfer, with an occasional idle burst ahead of it
    task automatic send_char(input logic dir, input logic [CHAR_W-1:0] c,
                             input logic eon, input logic eol);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        is_dir      <= dir;
        name_char   <= c;
        end_of_name <= eon;
        end_of_list <= eol;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        chars_sent++;
    endtask

    // wait out the listing, then the sort tail, before touching the register
    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // name byte biased toward a few letters so ties and prefixes show up
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 5))
            0: return 8'h61;
            1: return 8'h41;
            2: return 8'h62;
            3: return 8'h42;
            default: return CHAR_W'($urandom_range(1, 255));
        endcase
    endfunction

    // one whole listing with random content
    task automatic send_listing();
        int n_ent;
        int n_len;
        logic dir;
        logic eol;
        n_ent = ($urandom_range(0, 19) == 0) ? 64 + $urandom_range(0, 3)
                                             : $urandom_range(1, 10);
        for (int e = 0; e < n_ent; e++)
        begin
            if (n_ent > 60)
            begin
                n_len = $urandom_range(1, 2);
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                n_len = $urandom_range(60, 70);
            end
            else
            begin
                n_len = $urandom_range(1, 6);
            end
            dir = 1'($urandom_range(0, 1));
            for (int k = 0; k < n_len; k++)
            begin
                eol = (e == n_ent - 1) && (k == n_len - 1);
                send_char(dir, pick_char(),
                          (k == n_len - 1) ? (eol ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0,
                          eol);
            end
        end
    endtask

    // receiver stalls in bursts, never in the final stretch
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: folding, stability, byte extremes, list end mid-name
        write_limit(7'd64);
        send_char(1'b0, 8'h5A, 1'b0, 1'b0);
        send_char(1'b0, 8'h62, 1'b1, 1'b0);
        send_char(1'b1, 8'h61, 1'b1, 1'b0);
        send_char(1'b1, 8'h41, 1'b1, 1'b0);
        send_char(1'b0, 8'hFF, 1'b1, 1'b0);
        send_char(1'b0, 8'h01, 1'b1, 1'b0);
        send_char(1'b0, 8'h7A, 1'b1, 1'b0);
        send_char(1'b0, 8'h7A, 1'b0, 1'b0);
        send_char(1'b0, 8'h62, 1'b0, 1'b1);

        // zero limit drops everything
        write_limit(7'd0);
        send_char(1'b1, 8'h61, 1'b1, 1'b0);
        send_char(1'b0, 8'h62, 1'b1, 1'b1);

        // small limit drops the tail of the listing
        write_limit(7'd3);
        for (int i = 0; i < 5; i++)
        begin
            send_char(1'($urandom_range(0, 1)), 8'h65 - 8'(i), 1'b1, i == 4);
        end

        // limit above the store size clamps
        write_limit(7'd127);
        send_char(1'b0, 8'h80, 1'b1, 1'b0);
        send_char(1'b1, 8'h5B, 1'b1, 1'b1);

        // random listings under a changing limit
        while (chars_sent < 500)
        begin
            if (chars_sent > 420)
            begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_limit(7'd64);
                    1: write_limit(7'd127);
                    2: write_limit(7'd1);
                    3: write_limit(7'd0);
                    default: write_limit(CFG_W'($urandom_range(0, 127)));
                endcase
            end
            send_listing();
        end

        settle();
        if (failures == 0)
        begin
            $display("directory_entry_sorter: match");
        end
        else
        begin
            $display("directory_entry_sorter: mismatch");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("directory_entry_sorter: mismatch");
        $finish;
    end

endmodule
